// ----- hdl/crpb_pkg.sv -----
package crpb_pkg;

    localparam int CAPACITY = 16;
    localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int OCC_W = $clog2(CAPACITY + 1);

    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [OCC_W-1:0] occ_t;

    localparam logic REQ_GET = 1'b0;
    localparam logic REQ_INSERT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_SWEEP,
        ST_INSERT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic lookup;
        logic sweep;
        logic insert;
    } dp_cmd_t;

    typedef struct packed {
        logic req_is_insert;
        logic hit;
        logic full;
        logic victim_found;
    } dp_status_t;

endpackage

// ----- hdl/crpb_if.sv -----
interface crpb_req_if;
    logic valid;
    logic ready;
    logic req_type;
    logic [31:0] page_id;
    logic [31:0] page_data;
    modport source (output valid, req_type, page_id, page_data, input ready);
    modport sink (input valid, req_type, page_id, page_data, output ready);
endinterface

interface crpb_rsp_if;
    logic valid;
    logic ready;
    logic found;
    logic [31:0] data_out;
    logic evicted;
    logic [31:0] evicted_id;
    modport source (output valid, found, data_out, evicted, evicted_id, input ready);
    modport sink (input valid, found, data_out, evicted, evicted_id, output ready);
endinterface

// ----- hdl/crpb_ctrl.sv -----
module crpb_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  crpb_pkg::dp_status_t status,
    output crpb_pkg::dp_cmd_t    cmd
);
    crpb_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= crpb_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            crpb_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = crpb_pkg::ST_LOOKUP;
                end
            end
            crpb_pkg::ST_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                if (!status.req_is_insert || status.hit)
                    state_next = crpb_pkg::ST_DONE;
                else if (status.full)
                    state_next = crpb_pkg::ST_SWEEP;
                else
                    state_next = crpb_pkg::ST_INSERT;
            end
            crpb_pkg::ST_SWEEP:
            begin
                cmd.sweep = 1'b1;
                if (status.victim_found)
                    state_next = crpb_pkg::ST_INSERT;
            end
            crpb_pkg::ST_INSERT:
            begin
                cmd.insert = 1'b1;
                state_next = crpb_pkg::ST_DONE;
            end
            crpb_pkg::ST_DONE:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = crpb_pkg::ST_IDLE;
            end
            default: state_next = crpb_pkg::ST_IDLE;
        endcase
    end
endmodule

// ----- hdl/crpb_datapath.sv -----
module crpb_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  crpb_pkg::dp_cmd_t    cmd,
    output crpb_pkg::dp_status_t status,
    input  logic                 req_type,
    input  logic [31:0]          page_id,
    input  logic [31:0]          page_data,
    output logic                 found,
    output logic [31:0]          data_out,
    output logic                 evicted,
    output logic [31:0]          evicted_id
);
    localparam int N = crpb_pkg::CAPACITY;

    logic [N-1:0] valid_reg, ref_reg;
    logic [31:0] key_reg [N];
    logic [31:0] handle_reg [N];
    crpb_pkg::slot_t next_reg [N];
    crpb_pkg::slot_t prev_reg [N];
    crpb_pkg::slot_t head_reg, hand_reg;
    crpb_pkg::occ_t occ_reg;

    logic req_type_reg;
    logic [31:0] id_reg, data_reg;
    logic found_reg, evicted_reg;
    logic [31:0] dout_reg, evid_reg;

    logic [N-1:0] match;
    logic hit;
    crpb_pkg::slot_t hit_idx, free_idx;
    logic free_any;

    always_comb
    begin
        hit = 1'b0;
        hit_idx = '0;
        free_idx = '0;
        free_any = 1'b0;
        for (int i = 0; i < N; i++)
            match[i] = valid_reg[i] && (key_reg[i] == id_reg);
        for (int i = N - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                hit = 1'b1;
                hit_idx = crpb_pkg::slot_t'(i);
            end
            if (!valid_reg[i])
            begin
                free_any = 1'b1;
                free_idx = crpb_pkg::slot_t'(i);
            end
        end
    end

    assign status.req_is_insert = (req_type_reg == crpb_pkg::REQ_INSERT);
    assign status.hit = hit;
    assign status.full = (occ_reg >= crpb_pkg::occ_t'(N));
    assign status.victim_found = !ref_reg[hand_reg];

    crpb_pkg::slot_t h, nx, pv, tl, hd;
    assign h = hand_reg;
    assign nx = next_reg[h];
    assign pv = prev_reg[h];
    assign hd = head_reg;
    assign tl = prev_reg[head_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            ref_reg <= '0;
            head_reg <= '0;
            hand_reg <= '0;
            occ_reg <= '0;
        end
        else
        begin
            if (cmd.lookup && hit)
                ref_reg[hit_idx] <= 1'b1;
            if (cmd.sweep)
            begin
                if (ref_reg[h])
                begin
                    ref_reg[h] <= 1'b0;
                    hand_reg <= nx;
                end
                else
                begin
                    valid_reg[h] <= 1'b0;
                    if (nx != h)
                    begin
                        if (head_reg == h)
                            head_reg <= nx;
                        hand_reg <= nx;
                    end
                    occ_reg <= occ_reg - crpb_pkg::occ_t'(1);
                end
            end
            if (cmd.insert && free_any)
            begin
                valid_reg[free_idx] <= 1'b1;
                ref_reg[free_idx] <= 1'b0;
                occ_reg <= occ_reg + crpb_pkg::occ_t'(1);
                if (occ_reg == '0)
                begin
                    head_reg <= free_idx;
                    hand_reg <= free_idx;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_type_reg <= req_type;
            id_reg <= page_id;
            data_reg <= page_data;
            found_reg <= 1'b0;
            dout_reg <= '0;
            evicted_reg <= 1'b0;
            evid_reg <= '0;
        end
        if (cmd.lookup && hit)
        begin
            found_reg <= 1'b1;
            if (req_type_reg == crpb_pkg::REQ_GET)
                dout_reg <= handle_reg[hit_idx];
        end
        if (cmd.sweep && !ref_reg[h])
        begin
            evicted_reg <= 1'b1;
            evid_reg <= key_reg[h];
            if (nx != h)
            begin
                next_reg[pv] <= nx;
                prev_reg[nx] <= pv;
            end
        end
        if (cmd.insert && free_any)
        begin
            key_reg[free_idx] <= id_reg;
            handle_reg[free_idx] <= data_reg;
            if (occ_reg == '0)
            begin
                next_reg[free_idx] <= free_idx;
                prev_reg[free_idx] <= free_idx;
            end
            else
            begin
                next_reg[tl] <= free_idx;
                prev_reg[free_idx] <= tl;
                next_reg[free_idx] <= hd;
                prev_reg[hd] <= free_idx;
            end
        end
    end

    assign found = found_reg;
    assign data_out = dout_reg;
    assign evicted = evicted_reg;
    assign evicted_id = evid_reg;
endmodule

// ----- hdl/clock_replacement_page_buffer_core.sv -----
// get or resident insert: the request is registered on accept, looked up, then its result is presented
// an insert with a free frame adds an insert step for the link update
// a full buffer adds one sweep step per frame the hand visits, up to CAPACITY+1 frames
// so the time one word takes is set by the clock hand sweep loop
// one request is in flight at a time; a result holds until taken
// rst_n (asynchronous, active low) empties the buffer and parks head and hand at frame 0
module clock_replacement_page_buffer_core (
    input logic    clk,
    input logic    rst_n,
    crpb_req_if.sink   req,
    crpb_rsp_if.source rsp
);
    crpb_pkg::dp_cmd_t cmd;
    crpb_pkg::dp_status_t status;

    crpb_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(req.valid), .in_ready(req.ready),
        .out_valid(rsp.valid), .out_ready(rsp.ready),
        .status(status), .cmd(cmd)
    );

    crpb_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .status(status),
        .req_type(req.req_type), .page_id(req.page_id), .page_data(req.page_data),
        .found(rsp.found), .data_out(rsp.data_out),
        .evicted(rsp.evicted), .evicted_id(rsp.evicted_id)
    );
endmodule

// ----- hdl/crpb_checker.sv -----
module crpb_props (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic found,
    input logic [31:0] data_out,
    input logic evicted,
    input logic [31:0] evicted_id
);
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("input taken while result pending");
    a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready) else $error("ready after accept");
    a_evict_excl: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && evicted) |-> !found) else $error("eviction on hit");
    a_evid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !evicted) |-> (evicted_id == 32'd0)) else $error("stray evicted id");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(data_out)))
        else $error("result dropped");
endmodule

bind clock_replacement_page_buffer_core crpb_props u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(req.valid), .in_ready(req.ready),
    .out_valid(rsp.valid), .out_ready(rsp.ready),
    .found(rsp.found), .data_out(rsp.data_out),
    .evicted(rsp.evicted), .evicted_id(rsp.evicted_id)
);

// ----- tb/sv/crpb_checker.sv -----
`timescale 1ns / 1ps
module crpb_checker (
    input  logic       clk,
    input  logic       rst_n,
    crpb_req_if        req,
    crpb_rsp_if        rsp,
    output int         fail_count,
    output int         pending
);
    typedef struct packed {
        logic        found;
        logic [31:0] data_out;
        logic        evicted;
        logic [31:0] evicted_id;
    } page_rsp_t;

    logic            frame_valid [crpb_pkg::CAPACITY];
    logic [31:0]     frame_key [crpb_pkg::CAPACITY];
    logic [31:0]     frame_handle [crpb_pkg::CAPACITY];
    logic            frame_ref [crpb_pkg::CAPACITY];
    crpb_pkg::slot_t ring_next [crpb_pkg::CAPACITY];
    crpb_pkg::slot_t ring_prev [crpb_pkg::CAPACITY];
    crpb_pkg::slot_t head_q;
    crpb_pkg::slot_t hand_q;
    int              resident;
    page_rsp_t       rsp_queue [$];

    function automatic page_rsp_t buffer_access(logic kind, logic [31:0] id, logic [31:0] hdl);
        page_rsp_t r;
        int hit;
        int fs;
        crpb_pkg::slot_t h;
        crpb_pkg::slot_t nx;
        crpb_pkg::slot_t pv;
        crpb_pkg::slot_t tl;
        r = '0;
        hit = -1;
        fs = 0;
        for (int i = 0; i < crpb_pkg::CAPACITY; i++)
            if (hit < 0 && frame_valid[i] && frame_key[i] == id)
                hit = i;
        if (hit >= 0)
        begin
            frame_ref[hit] = 1'b1;
            r.found = 1'b1;
            if (kind == crpb_pkg::REQ_GET)
                r.data_out = frame_handle[hit];
        end
        else if (kind == crpb_pkg::REQ_INSERT)
        begin
            if (resident >= crpb_pkg::CAPACITY)
            begin
                r.evicted = 1'b1;
                for (int g = 0; g < 2 * crpb_pkg::CAPACITY + 2; g++)
                begin
                    h = hand_q;
                    if (!frame_ref[h])
                    begin
                        r.evicted_id = frame_key[h];
                        nx = ring_next[h];
                        pv = ring_prev[h];
                        frame_valid[h] = 1'b0;
                        if (nx != h)
                        begin
                            ring_next[pv] = nx;
                            ring_prev[nx] = pv;
                            if (head_q == h)
                                head_q = nx;
                            hand_q = nx;
                        end
                        resident--;
                        break;
                    end
                    frame_ref[h] = 1'b0;
                    hand_q = ring_next[h];
                end
            end
            for (int i = crpb_pkg::CAPACITY - 1; i >= 0; i--)
                if (!frame_valid[i])
                    fs = i;
            frame_valid[fs] = 1'b1;
            frame_key[fs] = id;
            frame_handle[fs] = hdl;
            frame_ref[fs] = 1'b0;
            if (resident == 0)
            begin
                head_q = crpb_pkg::slot_t'(fs);
                hand_q = crpb_pkg::slot_t'(fs);
                ring_next[fs] = crpb_pkg::slot_t'(fs);
                ring_prev[fs] = crpb_pkg::slot_t'(fs);
            end
            else
            begin
                tl = ring_prev[head_q];
                ring_next[tl] = crpb_pkg::slot_t'(fs);
                ring_prev[fs] = tl;
                ring_next[fs] = head_q;
                ring_prev[head_q] = crpb_pkg::slot_t'(fs);
            end
            resident++;
        end
        return r;
    endfunction

    assign pending = rsp_queue.size();

    always @(posedge clk or negedge rst_n)
    begin
        page_rsp_t e;
        if (!rst_n)
        begin
            for (int i = 0; i < crpb_pkg::CAPACITY; i++)
            begin
                frame_valid[i] = 1'b0;
                frame_ref[i] = 1'b0;
            end
            head_q = '0;
            hand_q = '0;
            resident = 0;
            fail_count = 0;
            rsp_queue.delete();
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (rsp_queue.size() == 0)
                begin
                    $error("unexpected response word");
                    fail_count++;
                end
                else
                begin
                    e = rsp_queue.pop_front();
                    if (rsp.found !== e.found)
                    begin
                        $error("found exp %0h got %0h", e.found, rsp.found);
                        fail_count++;
                    end
                    if (rsp.data_out !== e.data_out)
                    begin
                        $error("data_out exp %0h got %0h", e.data_out, rsp.data_out);
                        fail_count++;
                    end
                    if (rsp.evicted !== e.evicted)
                    begin
                        $error("evicted exp %0h got %0h", e.evicted, rsp.evicted);
                        fail_count++;
                    end
                    if (rsp.evicted_id !== e.evicted_id)
                    begin
                        $error("evicted_id exp %0h got %0h", e.evicted_id, rsp.evicted_id);
                        fail_count++;
                    end
                end
            end
            if (req.valid && req.ready)
                rsp_queue.push_back(buffer_access(req.req_type, req.page_id, req.page_data));
        end
    end
endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   cycle_count = 0;
    logic [31:0] id_pool [24];

    crpb_req_if req ();
    crpb_rsp_if rsp ();

    clock_replacement_page_buffer_core u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    crpb_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 9) < 6)
            return 0;
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // sink side stalls
    initial
    begin
        int g;
        rsp.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (cycle_count % 3000 < 600)
                rsp.ready <= 1'b1;
            else
            begin
                g = gap_len();
                rsp.ready <= (g == 0);
            end
        end
    end

    task automatic send_word(logic kind, logic [31:0] id, logic [31:0] hdl);
        int g;
        g = (cycle_count % 3000 < 600) ? 0 : gap_len();
        if (g > 0)
        begin
            req.valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        req.valid <= 1'b1;
        req.req_type <= kind;
        req.page_id <= id;
        req.page_data <= hdl;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] id;
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.req_type = crpb_pkg::REQ_GET;
        req.page_id = '0;
        req.page_data = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < 24; i++)
            id_pool[i] = (i < 2) ? (i == 0 ? 32'h0 : 32'hFFFF_FFFF) : $urandom;

        // directed: empty get, fill, resident insert, hits, eviction
        send_word(crpb_pkg::REQ_GET, 32'h0, 32'hFFFF_FFFF);
        send_word(crpb_pkg::REQ_INSERT, 32'h0, 32'hFFFF_FFFF);
        send_word(crpb_pkg::REQ_INSERT, 32'h0, 32'h1234_5678);
        send_word(crpb_pkg::REQ_GET, 32'h0, 32'h0);
        send_word(crpb_pkg::REQ_INSERT, 32'hFFFF_FFFF, 32'h0);
        send_word(crpb_pkg::REQ_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        for (int i = 2; i < 18; i++)
            send_word(crpb_pkg::REQ_INSERT, id_pool[i], $urandom);
        send_word(crpb_pkg::REQ_GET, id_pool[5], 32'h0);
        send_word(crpb_pkg::REQ_INSERT, 32'hAAAA_5555, 32'h5555_AAAA);
        send_word(crpb_pkg::REQ_GET, 32'h0, 32'h0);

        for (int n = 0; n < 750; n++)
        begin
            if ($urandom_range(0, 9) < 8)
                id = id_pool[$urandom_range(0, 23)];
            else
                id = $urandom;
            send_word(logic'($urandom_range(0, 1)), id, $urandom);
        end
        req.valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (2 * crpb_pkg::CAPACITY + 10) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

// ----- clock_replacement_page_buffer_core.f -----
hdl/crpb_pkg.sv
hdl/crpb_if.sv
hdl/crpb_ctrl.sv
hdl/crpb_datapath.sv
hdl/clock_replacement_page_buffer_core.sv
hdl/crpb_checker.sv
tb/sv/crpb_checker.sv
tb/sv/tb_top.sv
